### hdl/tbh_pkg.sv
// Shared constants, request codes and inter-cell structs for the threshold bin histogram.
// No dependencies; compiled first.
`default_nettype none

package tbh_pkg;

	// defaults for the top-level parameters
	localparam int MAX_LEVELS_DEF  = 16;
	localparam int COUNT_WIDTH_DEF = 32;
	localparam int VALUE_WIDTH_DEF = 64;

	// fixed port widths
	localparam int REQ_W      = 3;
	localparam int PORT_VAL_W = 64;
	localparam int LVL_W      = 5;   // level index, bin index and levels_in_use
	localparam int PORT_CNT_W = 32;

	// request codes
	localparam logic [REQ_W-1:0] REQ_ADD    = 3'd0;
	localparam logic [REQ_W-1:0] REQ_LOAD   = 3'd1;
	localparam logic [REQ_W-1:0] REQ_ADJUST = 3'd2;
	localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd3;
	localparam logic [REQ_W-1:0] REQ_READ   = 3'd4;

	// request token walking the cell row
	typedef struct packed {
		logic             vld;
		logic [REQ_W-1:0] req;
		logic [LVL_W-1:0] n;
		logic [LVL_W-1:0] nl;
		logic             below0;   // sample below edge 0
		logic             top;      // sample at or above the last edge in use
		logic             hit;      // bin found (bottom bin or scan match)
		logic [LVL_W-1:0] hit_bin;
		logic             ge_prev;  // sample >= edge of previous cell
		logic             gt_prev;  // sample >  edge of previous cell
		logic             adj_ok;
	} tok_t;

	// update broadcast to all cells when a request retires
	typedef struct packed {
		logic             clr;
		logic             wr;
		logic             inc;
		logic [LVL_W-1:0] idx;
	} cmd_t;

endpackage

`default_nettype wire

### hdl/tbh_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on tbh_pkg.
`default_nettype none

interface tbh_req_if import tbh_pkg::*; ();
	logic                         valid;
	logic                         ready;
	logic [REQ_W-1:0]             req_type;
	logic signed [PORT_VAL_W-1:0] value;
	logic [LVL_W-1:0]             level_index;

	modport source (output valid, req_type, value, level_index, input ready);
	modport sink   (input valid, req_type, value, level_index, output ready);
endinterface

interface tbh_rsp_if import tbh_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [LVL_W-1:0]      bin_index;
	logic [PORT_CNT_W-1:0] bin_count;
	logic                  accepted;

	modport source (output valid, bin_index, bin_count, accepted, input ready);
	modport sink   (input valid, bin_index, bin_count, accepted, output ready);
endinterface

`default_nettype wire

### hdl/tbh_cell.sv
// One histogram cell: holds edge IDX and the count of bin IDX, evaluates the passing token.
// Depends on tbh_pkg.
`default_nettype none

module tbh_cell import tbh_pkg::*; #(
	parameter int IDX         = 0,
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  tok_t                          tok_i,
	input  logic [COUNT_WIDTH-1:0]        cnt_hit_i,
	input  logic [COUNT_WIDTH-1:0]        cnt_top_i,
	input  logic signed [VALUE_WIDTH-1:0] val_i,
	input  cmd_t                          cmd,
	input  logic signed [VALUE_WIDTH-1:0] wr_val,
	input  logic [COUNT_WIDTH-1:0]        wr_cnt,
	output tok_t                          tok_o,
	output logic [COUNT_WIDTH-1:0]        cnt_hit_o,
	output logic [COUNT_WIDTH-1:0]        cnt_top_o
);

	logic signed [VALUE_WIDTH-1:0] edge_q;
	logic [COUNT_WIDTH-1:0]        cnt_q;
	tok_t                          tok_q;
	logic [COUNT_WIDTH-1:0]        cnt_hit_q;
	logic [COUNT_WIDTH-1:0]        cnt_top_q;

	tok_t                   tok_n;
	logic [COUNT_WIDTH-1:0] cnt_hit_n;
	logic [COUNT_WIDTH-1:0] cnt_top_n;
	logic                   lt;
	logic                   gt;

	assign lt = val_i < edge_q;
	assign gt = edge_q < val_i;

	always_comb begin
		tok_n     = tok_i;
		cnt_hit_n = cnt_hit_i;
		cnt_top_n = cnt_top_i;
		if (tok_i.vld) begin
			case (tok_i.req)
				REQ_ADD: begin
					if (IDX == 0 && lt) begin
						tok_n.below0  = 1'b1;
						tok_n.hit     = 1'b1;
						tok_n.hit_bin = '0;
						cnt_hit_n     = cnt_q;
					end
					if (IDX >= 1 && int'(tok_i.nl) > IDX && tok_i.ge_prev && lt && !tok_i.hit) begin
						tok_n.hit     = 1'b1;
						tok_n.hit_bin = LVL_W'(IDX);
						cnt_hit_n     = cnt_q;
					end
					if (int'(tok_i.nl) == IDX + 1 && !lt)
						tok_n.top = 1'b1;
					if (int'(tok_i.nl) == IDX)
						cnt_top_n = cnt_q;
				end
				REQ_READ: begin
					if (int'(tok_i.n) == IDX)
						cnt_hit_n = cnt_q;
				end
				REQ_ADJUST: begin
					// lower neighbor checked here, upper neighbor one cell on
					if (int'(tok_i.n) == IDX && IDX != 0 && !tok_i.gt_prev)
						tok_n.adj_ok = 1'b0;
					if (int'(tok_i.n) + 1 == IDX && int'(tok_i.n) + 1 != int'(tok_i.nl) && !lt)
						tok_n.adj_ok = 1'b0;
				end
				default: begin
				end
			endcase
		end
		tok_n.ge_prev = !lt;
		tok_n.gt_prev = gt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else if (adv) begin
			tok_q <= tok_n;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cnt_hit_q <= cnt_hit_n;
			cnt_top_q <= cnt_top_n;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr && int'(cmd.idx) == IDX)
			edge_q <= wr_val;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.clr) begin
			cnt_q <= '0;
		end else if (cmd.inc && int'(cmd.idx) == IDX) begin
			cnt_q <= wr_cnt;
		end
	end

	assign tok_o     = tok_q;
	assign cnt_hit_o = cnt_hit_q;
	assign cnt_top_o = cnt_top_q;

endmodule

`default_nettype wire

### hdl/threshold_bin_histogram.sv
// One request is in flight at a time: a new request is accepted only after the previous one
//   has retired. The request token walks the row of MAX_LEVELS+1 cells one cell per cycle
//   while the row is not stalled, then retires into the response register.
// A waiting response stalls the row only when the next token reaches its end.
// Reset: all bin counts zero, levels_in_use = 1; edges are undefined until loaded.
// Depends on tbh_pkg, tbh_if and tbh_cell.
`default_nettype none

module threshold_bin_histogram import tbh_pkg::*; #(
	parameter int MAX_LEVELS  = MAX_LEVELS_DEF,
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	tbh_req_if.sink          req,
	tbh_rsp_if.source        rsp,
	input  logic             cfg_we,
	input  logic [LVL_W-1:0] cfg_wdata
);

	localparam int NCELL = MAX_LEVELS + 1;  // one cell per bin

	// --------------------------------------------------------------------
	// control state
	// --------------------------------------------------------------------
	logic             busy_q;      // one request in flight at a time
	logic [LVL_W-1:0] nl_q;        // levels_in_use
	logic             rsp_valid_q;
	logic [LVL_W-1:0]      bin_index_q;
	logic [PORT_CNT_W-1:0] bin_count_q;
	logic                  accepted_q;

	// sample / new edge of the request in flight, broadcast to cells 1..N
	logic signed [VALUE_WIDTH-1:0] val_q;
	logic signed [VALUE_WIDTH-1:0] in_val;

	logic acc;   // request accepted
	logic adv;   // row advances
	logic ld;    // token retires into the response register

	// token chain: tok[0] is the injected request, tok[g+1] is cell g's register
	tok_t                   tok   [NCELL+1];
	logic [COUNT_WIDTH-1:0] hit_c [NCELL+1];
	logic [COUNT_WIDTH-1:0] top_c [NCELL+1];
	logic signed [VALUE_WIDTH-1:0] cval [NCELL];
	logic [NCELL-1:0]       vld_vec;

	tok_t                   x;
	cmd_t                   cmd;
	cmd_t                   bc;
	logic [COUNT_WIDTH-1:0] cnt_sel;
	logic [COUNT_WIDTH-1:0] cnt_inc;
	logic [LVL_W-1:0]       res_bin;
	logic [COUNT_WIDTH-1:0] res_cnt;
	logic                   res_ok;
	logic [63:0]            res_cnt_wide;

	assign in_val    = req.value[VALUE_WIDTH-1:0];
	assign req.ready = !busy_q;
	assign acc       = req.valid && !busy_q;

	assign x   = tok[NCELL];
	// freeze the row only while a finished token waits on a full output register
	assign adv = !(x.vld && rsp_valid_q && !rsp.ready);
	assign ld  = x.vld && adv;

	// --------------------------------------------------------------------
	// request injection into cell 0
	// --------------------------------------------------------------------
	always_comb begin
		tok[0]        = '0;
		tok[0].vld    = acc;
		tok[0].req    = req.req_type;
		tok[0].n      = req.level_index;
		tok[0].nl     = nl_q;
		// adjust needs levels_in_use above 1 and an index below levels_in_use; cells refine it
		tok[0].adj_ok = (nl_q > 5'd1) && (req.level_index < nl_q);
	end
	assign hit_c[0] = '0;
	assign top_c[0] = '0;

	always_ff @(posedge clk) begin
		if (acc)
			val_q <= in_val;
	end

	// --------------------------------------------------------------------
	// cell row
	// --------------------------------------------------------------------
	for (genvar g = 0; g < NCELL; g++) begin : g_cell
		if (g == 0) begin : g_first
			assign cval[g] = in_val;   // cell 0 sees the request on the accept edge
		end else begin : g_rest
			assign cval[g] = val_q;
		end

		tbh_cell #(
			.IDX         (g),
			.COUNT_WIDTH (COUNT_WIDTH),
			.VALUE_WIDTH (VALUE_WIDTH)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.tok_i     (tok[g]),
			.cnt_hit_i (hit_c[g]),
			.cnt_top_i (top_c[g]),
			.val_i     (cval[g]),
			.cmd       (bc),
			.wr_val    (val_q),
			.wr_cnt    (cnt_inc),
			.tok_o     (tok[g+1]),
			.cnt_hit_o (hit_c[g+1]),
			.cnt_top_o (top_c[g+1])
		);

		assign vld_vec[g] = tok[g+1].vld;
	end

	// --------------------------------------------------------------------
	// retire: decide the result and the update broadcast
	// --------------------------------------------------------------------
	always_comb begin
		cmd     = '0;
		res_bin = '0;
		res_cnt = '0;
		res_ok  = 1'b0;
		// bottom bin wins over top bin, top bin over an inner match
		cnt_sel = (x.below0 || !x.top) ? hit_c[NCELL] : top_c[NCELL];
		cnt_inc = (&cnt_sel) ? cnt_sel : cnt_sel + COUNT_WIDTH'(1);  // saturating
		case (x.req)
			REQ_ADD: begin
				if (x.below0 || x.top || x.hit) begin
					cmd.inc = 1'b1;
					cmd.idx = x.below0 ? '0 : (x.top ? x.nl : x.hit_bin);
					res_bin = cmd.idx;
					res_cnt = cnt_inc;
					res_ok  = 1'b1;
				end
			end
			REQ_LOAD: begin
				if (x.n < x.nl) begin
					cmd.wr  = 1'b1;
					cmd.clr = 1'b1;
					cmd.idx = x.n;
					res_ok  = 1'b1;
				end
			end
			REQ_ADJUST: begin
				if (x.adj_ok) begin
					cmd.wr  = 1'b1;
					cmd.clr = 1'b1;
					cmd.idx = x.n;
					res_ok  = 1'b1;
				end
			end
			REQ_CLEAR: begin
				cmd.clr = 1'b1;
				res_ok  = 1'b1;
			end
			REQ_READ: begin
				if (x.n <= x.nl) begin
					res_bin = x.n;
					res_cnt = hit_c[NCELL];
					res_ok  = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// broadcast only on retire; a levels_in_use write clears counts too
	always_comb begin
		bc     = ld ? cmd : '0;
		bc.clr = bc.clr | cfg_we;
	end

	assign res_cnt_wide = 64'(res_cnt);

	// --------------------------------------------------------------------
	// control registers
	// --------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (acc) begin
			busy_q <= 1'b1;
		end else if (ld) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nl_q <= 5'd1;
		end else if (cfg_we) begin
			if (cfg_wdata == '0)
				nl_q <= 5'd1;
			else if (int'(cfg_wdata) > MAX_LEVELS)
				nl_q <= LVL_W'(MAX_LEVELS);
			else
				nl_q <= cfg_wdata;
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ld) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			bin_index_q <= res_bin;
			bin_count_q <= res_cnt_wide[PORT_CNT_W-1:0];
			accepted_q  <= res_ok;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.bin_index = bin_index_q;
	assign rsp.bin_count = bin_count_q;
	assign rsp.accepted  = accepted_q;

	// --------------------------------------------------------------------
	// assertions
	// --------------------------------------------------------------------
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(vld_vec) && (busy_q == (vld_vec != '0)))
		else $error("token count in cell row disagrees with busy");

	a_retire_frees: assert property (@(posedge clk) disable iff (!arst_n)
		ld |=> !busy_q && rsp_valid_q)
		else $error("retired request did not free the row or fill the response");

	a_no_clr_inc: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.clr && cmd.inc))
		else $error("clear and increment issued together");

	a_levels_range: assert property (@(posedge clk) disable iff (!arst_n)
		nl_q != '0 && int'(nl_q) <= MAX_LEVELS)
		else $error("levels_in_use out of range");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_vec))
		else $error("cell row moved while stalled");

endmodule

`default_nettype wire
